// ===== rtl/core/jsu_pkg.sv =====
package jsu_pkg;

  // Kinds of result word.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_END    = 2'd1,
    KIND_EOF    = 2'd2,
    KIND_BADHEX = 2'd3
  } kind_t;

  // Characters with a meaning of their own in a string body.
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // One result word before the last flag is attached.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } word_t;

  // Escape state carried from one byte to the next.
  typedef struct packed {
    logic        escape_pending;
    logic [2:0]  hex_digits_left;
    logic [15:0] code_accumulator;
  } dec_state_t;

  // Everything one input byte produces.
  typedef struct packed {
    logic [1:0]      count;
    word_t [2:0]     words;
    dec_state_t      next;
  } dec_result_t;

  // Hex digit value, with bit 4 set when the byte is a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Control codes of the single-letter escapes; anything else passes.
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = 8'h0A;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h74:   r = 8'h09;
      8'h72:   r = 8'h0D;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/jsu_if.sv =====
// Raw string body byte channel.
interface jsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Decoded result channel.
interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== rtl/core/jsu_decode.sv =====
module jsu_decode
  import jsu_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  dec_state_t  state,
  output dec_result_t res
);

  logic [4:0]  hex;
  logic [15:0] code;

  assign hex  = hex_value(in_byte);
  assign code = {state.code_accumulator[11:0], hex[3:0]};

  // One pass over the escape rules for the incoming byte.
  always_comb begin
    res.count = 2'd0;
    res.words = '0;
    res.next  = state;
    if (in_byte == CHAR_QUOTE && !state.escape_pending) begin
      res.count         = 2'd1;
      res.words[0].kind = KIND_END;
      res.next          = '0;
    end else if (in_byte == CHAR_NUL) begin
      res.count         = 2'd1;
      res.words[0].kind = KIND_EOF;
      res.next          = '0;
    end else if (state.hex_digits_left != 3'd0) begin
      if (!hex[4]) begin
        res.count         = 2'd1;
        res.words[0].kind = KIND_BADHEX;
        res.next          = '0;
      end else if (state.hex_digits_left == 3'd1) begin
        // Fourth digit: emit the code point in UTF-8.
        res.next = '0;
        if (code[15:7] == 9'd0) begin
          res.count         = 2'd1;
          res.words[0].data = {1'b0, code[6:0]};
        end else if (code[15:11] == 5'd0) begin
          res.count         = 2'd2;
          res.words[0].data = {3'b110, code[10:6]};
          res.words[1].data = {2'b10, code[5:0]};
        end else begin
          res.count         = 2'd3;
          res.words[0].data = {4'b1110, code[15:12]};
          res.words[1].data = {2'b10, code[11:6]};
          res.words[2].data = {2'b10, code[5:0]};
        end
      end else begin
        res.next.code_accumulator = code;
        res.next.hex_digits_left  = state.hex_digits_left - 3'd1;
      end
    end else if (in_byte == CHAR_BACKSLASH) begin
      if (state.escape_pending) begin
        res.count                = 2'd1;
        res.words[0].data        = in_byte;
        res.next.escape_pending  = 1'b0;
      end else begin
        res.next.escape_pending  = 1'b1;
      end
    end else if (in_byte == CHAR_U && state.escape_pending) begin
      res.next.hex_digits_left  = HEX_DIGITS;
      res.next.code_accumulator = 16'd0;
    end else begin
      res.count               = 2'd1;
      res.words[0].data       = state.escape_pending ? map_escape(in_byte) : in_byte;
      res.next.escape_pending = 1'b0;
    end
  end

endmodule

// ===== rtl/core/jsu_emit.sv =====
module jsu_emit
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [1:0]   load_count,
  input  word_t [2:0]  load_words,
  output logic         can_load,
  jsu_result_if.source dst
);

  word_t [2:0] words;
  logic  [1:0] cnt;
  logic        take;

  assign take     = dst.valid && dst.ready;
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && dst.ready);

  assign dst.valid    = (cnt != 2'd0);
  assign dst.out_byte = words[0].data;
  assign dst.kind     = words[0].kind;
  assign dst.last     = (cnt == 2'd1);

  // Result register: a new group loads as the old one drains, else shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= load_words;
    end else if (take) begin
      words[0] <= words[1];
      words[1] <= words[2];
    end
  end

endmodule

// ===== rtl/core/json_string_unescape.sv =====
// JSON string body unescaper. Feed the bytes after the opening quote on raw;
// decoded bytes, the string end and the two error kinds come out on decoded,
// with last marking the final word caused by each input byte. One byte is
// taken per cycle unless decoded stalls; a byte that decodes to two or three
// UTF-8 bytes holds raw while the result register drains, and bytes that
// produce nothing (an opening backslash, the u, the first three hex digits)
// do not hold raw. A byte's first word is registered and valid the cycle after
// it is taken. The escape state clears after every string end or error.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  jsu_byte_if.sink     raw,
  jsu_result_if.source decoded
);

  dec_state_t  state;
  dec_result_t res;
  logic        can_load;
  logic        accept;

  assign raw.ready = can_load;
  assign accept    = raw.valid && raw.ready;

  jsu_decode u_decode (
    .in_byte (raw.in_byte),
    .state   (state),
    .res     (res)
  );

  jsu_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && res.count != 2'd0),
    .load_count (res.count),
    .load_words (res.words),
    .can_load   (can_load),
    .dst        (decoded)
  );

  // Escape state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= res.next;
    end
  end

  // Hex collection only runs inside an escape, and never above four digits.
  a_hex_in_escape: assert property (@(posedge clk) disable iff (rst)
    state.hex_digits_left != 3'd0 |-> state.escape_pending && state.hex_digits_left <= HEX_DIGITS)
    else $error("hex countdown outside an escape");

  // End and error words are always alone in their group.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && decoded.kind != KIND_DATA |-> decoded.last)
    else $error("status word not marked last");

  // A word that is not last is always followed by another one.
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && decoded.ready && !decoded.last |=> decoded.valid)
    else $error("result group broken off");

  // No byte is taken while a group has more than its final word to give.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    raw.valid && raw.ready |-> !decoded.valid || (decoded.last && decoded.ready))
    else $error("byte taken over a pending group");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 6_000_000;

  // Letters of the single-letter escapes and a few other bytes of interest.
  localparam logic [7:0] LETTER_N     = "n";
  localparam logic [7:0] LETTER_B     = "b";
  localparam logic [7:0] LETTER_F     = "f";
  localparam logic [7:0] LETTER_T     = "t";
  localparam logic [7:0] LETTER_R     = "r";
  localparam logic [7:0] CHAR_SLASH   = "/";
  localparam logic [7:0] CODE_LF      = 8'h0A;
  localparam logic [7:0] CODE_BS      = 8'h08;
  localparam logic [7:0] CODE_FF      = 8'h0C;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [7:0] CODE_CR      = 8'h0D;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } decoded_word_t;

  // Keeps its own copy of the escape state and the words still owed.
  class utf8_unescaper;
    logic          esc_pending;
    logic [2:0]    digits_left;
    logic [15:0]   code_point;
    decoded_word_t owed_words[$];
    int            mismatches;
    int            bytes_taken;
    int            words_seen;
    int            ends_seen;
    int            errors_seen;

    function new();
      clear_escape();
      mismatches  = 0;
      bytes_taken = 0;
      words_seen  = 0;
      ends_seen   = 0;
      errors_seen = 0;
    endfunction

    function void clear_escape();
      esc_pending = 1'b0;
      digits_left = 3'd0;
      code_point  = 16'd0;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Case is folded so that one range covers both letter forms.
    function void decode_hex(input logic [7:0] c, output logic ok, output logic [3:0] nib);
      logic [7:0] folded;
      folded = c | 8'h20;
      ok  = 1'b0;
      nib = 4'd0;
      if (c >= "0" && c <= "9") begin
        ok  = 1'b1;
        nib = c[3:0];
      end else if (folded >= "a" && folded <= "f") begin
        ok  = 1'b1;
        nib = folded[3:0] + 4'd9;
      end
    endfunction

    function logic [7:0] control_code(input logic [7:0] c);
      case (c)
        LETTER_N: return CODE_LF;
        LETTER_B: return CODE_BS;
        LETTER_F: return CODE_FF;
        LETTER_T: return CODE_TAB;
        LETTER_R: return CODE_CR;
        default:  return c;
      endcase
    endfunction

    // Works out the words that one accepted byte causes.
    function void take_byte(input logic [7:0] c);
      int         n;
      logic [7:0] wd [3];
      kind_t      wk [3];
      logic       ok;
      logic [3:0] nib;
      logic [15:0] v;
      n = 0;
      bytes_taken++;
      for (int i = 0; i < 3; i++) begin
        wd[i] = 8'd0;
        wk[i] = KIND_DATA;
      end
      if (c == CHAR_QUOTE && !esc_pending) begin
        wk[0] = KIND_END;
        n = 1;
        clear_escape();
      end else if (c == CHAR_NUL) begin
        wk[0] = KIND_EOF;
        n = 1;
        clear_escape();
      end else if (digits_left != 3'd0) begin
        decode_hex(c, ok, nib);
        if (!ok) begin
          wk[0] = KIND_BADHEX;
          n = 1;
          clear_escape();
        end else begin
          code_point  = {code_point[11:0], nib};
          digits_left = digits_left - 3'd1;
          if (digits_left == 3'd0) begin
            v = code_point;
            if (v <= 16'h007F) begin
              wd[0] = v[7:0];
              n = 1;
            end else if (v <= 16'h07FF) begin
              wd[0] = {3'b110, v[10:6]};
              wd[1] = {2'b10, v[5:0]};
              n = 2;
            end else begin
              wd[0] = {4'b1110, v[15:12]};
              wd[1] = {2'b10, v[11:6]};
              wd[2] = {2'b10, v[5:0]};
              n = 3;
            end
            clear_escape();
          end
        end
      end else if (c == CHAR_BACKSLASH) begin
        if (esc_pending) begin
          wd[0] = c;
          n = 1;
          esc_pending = 1'b0;
        end else begin
          esc_pending = 1'b1;
        end
      end else if (c == CHAR_U && esc_pending) begin
        digits_left = HEX_DIGITS;
        code_point  = 16'd0;
      end else begin
        wd[0] = esc_pending ? control_code(c) : c;
        n = 1;
        esc_pending = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        owed_words.push_back('{data: wd[i], kind: wk[i], last: (i == n - 1)});
        if (wk[i] == KIND_END) ends_seen++;
        else if (wk[i] != KIND_DATA) errors_seen++;
      end
    endfunction

    task report(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compares one accepted word with the oldest word owed.
    task match_word(input logic [7:0] d, input logic [1:0] k, input logic l);
      decoded_word_t w;
      words_seen++;
      if (owed_words.size() == 0) begin
        report($sformatf("word data=%02h kind=%0d last=%0b with nothing owed", d, k, l));
      end else begin
        w = owed_words.pop_front();
        if (d !== w.data)
          report($sformatf("out_byte %02h, wanted %02h", d, w.data));
        if (k !== w.kind)
          report($sformatf("kind %0d, wanted %0d", k, w.kind));
        if (l !== w.last)
          report($sformatf("last %0b, wanted %0b", l, w.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic idle_on    = 1'b1;
  logic start_hold = 1'b0;
  logic hold_off   = 1'b0;

  utf8_unescaper predictor;
  logic [7:0]    byte_plan[$];

  jsu_byte_if   raw_if();
  jsu_result_if res_if();

  json_string_unescape dut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .decoded (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    if (nib < 4'd10) begin
      base = "0";
      return base + 8'(nib);
    end
    base = ($urandom_range(0, 1) != 0) ? "A" : "a";
    return base + 8'(nib) - 8'd10;
  endfunction

  function automatic void plan_unicode(input logic [15:0] v);
    byte_plan.push_back(CHAR_BACKSLASH);
    byte_plan.push_back(CHAR_U);
    for (int i = 3; i >= 0; i--) byte_plan.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  // Appends one random piece of string body: a byte, an escape, a quote or a NUL.
  function automatic void plan_sequence();
    int         pick;
    int         good;
    logic [7:0] b;
    logic [15:0] v;
    logic [15:0] edges [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    logic [7:0]  letters [8] = '{LETTER_N, LETTER_B, LETTER_F, LETTER_T, LETTER_R,
                                 CHAR_BACKSLASH, CHAR_QUOTE, CHAR_SLASH};
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      b = 8'($urandom_range(1, 255));
      if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) b = b + 8'd1;
      byte_plan.push_back(b);
    end else if (pick < 55) begin
      byte_plan.push_back(CHAR_BACKSLASH);
      if ($urandom_range(0, 4) == 0) byte_plan.push_back(8'($urandom_range(1, 255)));
      else byte_plan.push_back(letters[$urandom_range(0, 7)]);
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       v = edges[$urandom_range(0, 5)];
        1:       v = 16'($urandom_range(0, 16'h007F));
        2:       v = 16'($urandom_range(16'h0080, 16'h07FF));
        default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      plan_unicode(v);
    end else if (pick < 85) begin
      // A unicode escape cut short by a byte that is not a hex digit.
      byte_plan.push_back(CHAR_BACKSLASH);
      byte_plan.push_back(CHAR_U);
      good = $urandom_range(0, 3);
      for (int i = 0; i < good; i++) byte_plan.push_back(hex_char(4'($urandom_range(0, 15))));
      case ($urandom_range(0, 3))
        0:       b = CHAR_QUOTE;
        1:       b = CHAR_NUL;
        default: begin
          b = 8'($urandom_range(0, 255));
          while (is_hex_char(b)) b = 8'($urandom_range(0, 255));
        end
      endcase
      byte_plan.push_back(b);
    end else if (pick < 91) begin
      byte_plan.push_back(CHAR_QUOTE);
    end else if (pick < 94) begin
      byte_plan.push_back(CHAR_NUL);
    end else begin
      byte_plan.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Offers one byte, after a random gap while idle_on is set, and notes it once it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      raw_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_if.valid   <= 1'b1;
    raw_if.in_byte <= b;
    do @(posedge clk); while (!raw_if.ready);
    predictor.take_byte(b);
  endtask

  task automatic send_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
  endtask

  // Stops offering until every owed word has come out.
  task automatic wait_drained();
    raw_if.valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Long receiver hold-off while the sender keeps going.
  initial begin
    wait (start_hold);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result side: check every accepted word, then choose the next ready.
  initial begin
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready)
        predictor.match_word(res_if.out_byte, res_if.kind, res_if.last);
      if (rst || hold_off) begin
        res_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_on) stall = rand_gap();
      end
    end
  end

  initial begin
    int sent;
    int chunk;
    predictor = new();
    rst            <= 1'b1;
    raw_if.valid   <= 1'b0;
    raw_if.in_byte <= 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, escapes, two- and three-byte code point sizes,
    // a quote inside a unicode escape, a NUL inside an escape, the end quote.
    byte_plan = '{8'hFF, 8'h01,
                  CHAR_BACKSLASH, LETTER_N,
                  CHAR_BACKSLASH, CHAR_BACKSLASH,
                  CHAR_BACKSLASH, CHAR_QUOTE,
                  CHAR_BACKSLASH, CHAR_U, "0", "7", "F", "f",
                  CHAR_BACKSLASH, CHAR_U, "f", "F", "F", "F",
                  CHAR_BACKSLASH, CHAR_U, CHAR_QUOTE,
                  CHAR_BACKSLASH, CHAR_NUL,
                  CHAR_QUOTE};
    send_plan();
    wait_drained();

    // Random part, with the long hold-off at its start and stretches without gaps or stalls.
    start_hold <= 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on <= ((sent / 60) % 4) != 3;
      plan_sequence();
      chunk = byte_plan.size();
      sent += chunk;
      send_plan();
      if (sent >= RANDOM_ITEMS / 2 && sent - chunk < RANDOM_ITEMS / 2)
        wait_drained();
    end
    idle_on <= 1'b1;
    wait_drained();

    $display("Run covered %0d input bytes and %0d result words.",
             predictor.bytes_taken, predictor.words_seen);
    $display("Among them %0d string ends and %0d error words, with stalls on both sides.",
             predictor.ends_seen, predictor.errors_seen);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== json_string_unescape.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_emit.sv
rtl/core/json_string_unescape.sv
bench/testbench.sv
